@@ sv/ipacl_pkg.sv @@
// Shared types and constants for the IPv4 prefix access filter.
package ipacl_pkg;

    localparam int MAX_RULES = 64;
    localparam int ADDR_W    = 32;
    localparam int LEN_W     = 6;
    localparam int CNT_W     = $clog2(MAX_RULES + 1);

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(ADDR_W);

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    // Request as it travels down the rule chain
    typedef struct packed
    {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] mask;
        logic              permit;
        logic [CNT_W-1:0]  remain;   // insert: hops to target slot; query: rules left
        logic              allowed;
        logic              status;
    } item_t;

endpackage

@@ sv/ipacl_cell.sv @@
// One rule slot of the filter chain: holds a rule and forwards the request.
module ipacl_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  ipacl_pkg::item_t      in_item,
    output logic                  out_valid,
    output ipacl_pkg::item_t      out_item
);

    logic [ipacl_pkg::ADDR_W-1:0] rule_addr_reg;
    logic [ipacl_pkg::ADDR_W-1:0] rule_mask_reg;
    logic                         rule_verdict_reg;
    logic                         valid_reg;
    ipacl_pkg::item_t             item_reg;
    ipacl_pkg::item_t             item_next;
    logic                         match;
    logic                         write_rule;

    // Rule hit test against the passing address
    assign match = ((rule_addr_reg ^ in_item.addr) & rule_mask_reg) == '0;

    // Insert lands here when its hop count has run out
    assign write_rule = en && in_valid && (in_item.cmd == ipacl_pkg::CMD_INSERT)
                        && !in_item.status && (in_item.remain == '0);

    // Update the request for the next slot
    always_comb
    begin
        item_next = in_item;
        if (in_item.cmd == ipacl_pkg::CMD_QUERY)
        begin
            // later slots hold newer rules, so a later hit overrides
            if (in_item.remain != '0)
            begin
                if (match)
                begin
                    item_next.allowed = rule_verdict_reg;
                end
                item_next.remain = in_item.remain - ipacl_pkg::CNT_W'(1);
            end
        end
        else
        begin
            // wraps past zero so it never fires again within the chain
            item_next.remain = in_item.remain - ipacl_pkg::CNT_W'(1);
        end
    end

    // Rule storage
    always_ff @(posedge clk)
    begin
        if (write_rule)
        begin
            rule_addr_reg    <= in_item.addr;
            rule_mask_reg    <= in_item.mask;
            rule_verdict_reg <= in_item.permit;
        end
    end

    // Request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/ip_prefix_acl_filter_top.sv @@
// Top level of the IPv4 prefix access filter: request head, rule chain, output.
//
// Usage:
//   Slave channel s_axis_*: tuser is the command (0 insert, 1 query);
//   tdata carries address, prefix length and permit. Master channel m_axis_*
//   returns one result per request: allowed and status (table full on insert).
//   Requests walk a chain of MAX_RULES rule cells, one cell per cycle while
//   the chain advances; each cell holds one rule. An insert drops its rule
//   into the slot given by the rule count at acceptance; a query keeps the
//   verdict of the newest rule that covers its address, or allows it when
//   none does. Throughput: one request per cycle while the chain advances,
//   set by the single stage each cell adds. The last cell's stage is the
//   output register. When the receiver stalls, the whole chain holds and
//   s_axis_tready drops until the result is taken. Reset clears the rule
//   count and all stage valid bits; stored rules are not cleared, since a
//   query only looks at slots below its rule count.
module ip_prefix_acl_filter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] address, [37:32] prefix_length,
                                        // [38] permit, [39] zero
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] allowed, [1] status, [7:2] zero
);

    localparam int N = ipacl_pkg::MAX_RULES;

    logic                            advance;
    logic [ipacl_pkg::CNT_W-1:0]     count_reg;
    logic [ipacl_pkg::CNT_W-1:0]     count_next;
    logic                            full;
    logic                            accept;
    logic [ipacl_pkg::LEN_W-1:0]     len_sat;
    ipacl_pkg::item_t                head_item;
    logic                            chain_valid [N+1];
    ipacl_pkg::item_t                chain_item  [N+1];

    // Chain moves whenever the output slot is free or being taken
    assign advance       = !chain_valid[N] || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign full          = count_reg == ipacl_pkg::CNT_W'(N);

    // Request head: saturate length, build mask, stamp rule count, preset verdict and status
    always_comb
    begin
        if (s_axis_tdata[37:32] > ipacl_pkg::FULL_LEN)
        begin
            len_sat = ipacl_pkg::FULL_LEN;
        end
        else
        begin
            len_sat = s_axis_tdata[37:32];
        end
        head_item.cmd    = ipacl_pkg::cmd_t'(s_axis_tuser);
        head_item.addr   = s_axis_tdata[31:0];
        head_item.permit = s_axis_tdata[38];
        head_item.remain = count_reg;
        if (len_sat == ipacl_pkg::FULL_LEN)
        begin
            head_item.mask = '1;
        end
        else
        begin
            head_item.mask = ~({ipacl_pkg::ADDR_W{1'b1}} >> len_sat);
        end
        head_item.allowed = head_item.cmd == ipacl_pkg::CMD_QUERY;
        head_item.status  = (head_item.cmd == ipacl_pkg::CMD_INSERT) && full;
    end

    // Rule count
    always_comb
    begin
        count_next = count_reg;
        if (accept && (head_item.cmd == ipacl_pkg::CMD_INSERT) && !full)
        begin
            count_next = count_reg + ipacl_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign chain_valid[0] = s_axis_tvalid;
    assign chain_item[0]  = head_item;

    // Rule chain
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ipacl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    // Output
    assign m_axis_tvalid = chain_valid[N];
    assign m_axis_tdata  = {6'b0, chain_item[N].status, chain_item[N].allowed};

endmodule
